[design/cgtc_pkg.sv]
`timescale 1ns / 1ps
package cgtc_pkg;

	localparam logic [1:0] KIND_CAL2SEC = 2'd0;
	localparam logic [1:0] KIND_SEC2CAL = 2'd1;
	localparam logic [1:0] KIND_SEC2GPS = 2'd2;

	localparam logic [2:0] DSEL_DAY  = 3'd0;
	localparam logic [2:0] DSEL_QUAD = 3'd1;
	localparam logic [2:0] DSEL_HOUR = 3'd2;
	localparam logic [2:0] DSEL_MIN  = 3'd3;
	localparam logic [2:0] DSEL_WEEK = 3'd4;

	localparam logic [11:0] YEAR_LO = 12'd1970;
	localparam logic [11:0] YEAR_HI = 12'd2099;
	localparam logic [32:0] GPS_EPOCH = 33'd315964800;

	typedef struct packed {
		logic       load_in;
		logic       cal0;
		logic       cal1;
		logic       div_start;
		logic [2:0] div_sel;
		logic       walk;
		logic       load_out;
	} cgtc_cmd_t;

	typedef struct packed {
		logic [1:0] kind;
		logic       div_busy;
		logic       walk_done;
	} cgtc_stat_t;

	function automatic logic [8:0] day_of_year_start(input logic [3:0] idx);
		logic [8:0] v;
		case (idx)
			4'd0: v = 9'd1;
			4'd1: v = 9'd32;
			4'd2: v = 9'd60;
			4'd3: v = 9'd91;
			4'd4: v = 9'd121;
			4'd5: v = 9'd152;
			4'd6: v = 9'd182;
			4'd7: v = 9'd213;
			4'd8: v = 9'd244;
			4'd9: v = 9'd274;
			4'd10: v = 9'd305;
			4'd11: v = 9'd335;
			default: v = 9'd0;
		endcase
		return v;
	endfunction

	function automatic logic [1:0] div12(input logic [5:0] m);
		logic [1:0] v;
		if (m >= 6'd36) v = 2'd3;
		else if (m >= 6'd24) v = 2'd2;
		else if (m >= 6'd12) v = 2'd1;
		else v = 2'd0;
		return v;
	endfunction

	// Month lengths across a four-year block whose third year is the leap year.
	function automatic logic [4:0] month_len(input logic [5:0] m);
		logic [3:0] mm;
		logic [4:0] v;
		mm = 4'(m - 6'd12 * 6'(div12(m)));
		case (mm)
			4'd1: v = (m == 6'd25) ? 5'd29 : 5'd28;
			4'd3, 4'd5, 4'd8, 4'd10: v = 5'd30;
			default: v = 5'd31;
		endcase
		return v;
	endfunction

endpackage

[design/cgtc_ctrl.sv]
`timescale 1ns / 1ps
module cgtc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	input  cgtc_pkg::cgtc_stat_t stat,
	output cgtc_pkg::cgtc_cmd_t  cmd
);
	import cgtc_pkg::*;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_DISP  = 4'd1;
	localparam logic [3:0] S_CAL0  = 4'd2;
	localparam logic [3:0] S_CAL1  = 4'd3;
	localparam logic [3:0] S_DAYW  = 4'd4;
	localparam logic [3:0] S_QUADW = 4'd5;
	localparam logic [3:0] S_WALK  = 4'd6;
	localparam logic [3:0] S_HOURW = 4'd7;
	localparam logic [3:0] S_MINW  = 4'd8;
	localparam logic [3:0] S_WEEKW = 4'd9;
	localparam logic [3:0] S_DONE  = 4'd10;

	logic [3:0] state_q, state_d;
	logic out_valid_q;

	assign in_stall = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				case (stat.kind)
					KIND_CAL2SEC: state_d = S_CAL0;
					KIND_SEC2CAL: begin
						cmd.div_start = 1'b1;
						cmd.div_sel = DSEL_DAY;
						state_d = S_DAYW;
					end
					KIND_SEC2GPS: begin
						cmd.div_start = 1'b1;
						cmd.div_sel = DSEL_WEEK;
						state_d = S_WEEKW;
					end
					default: state_d = S_DONE;
				endcase
			end
			S_CAL0: begin
				cmd.cal0 = 1'b1;
				state_d = S_CAL1;
			end
			S_CAL1: begin
				cmd.cal1 = 1'b1;
				state_d = S_DONE;
			end
			S_DAYW: begin
				if (!stat.div_busy) begin
					cmd.div_start = 1'b1;
					cmd.div_sel = DSEL_QUAD;
					state_d = S_QUADW;
				end
			end
			S_QUADW: begin
				if (!stat.div_busy) state_d = S_WALK;
			end
			S_WALK: begin
				if (stat.walk_done) begin
					cmd.div_start = 1'b1;
					cmd.div_sel = DSEL_HOUR;
					state_d = S_HOURW;
				end else begin
					cmd.walk = 1'b1;
				end
			end
			S_HOURW: begin
				if (!stat.div_busy) begin
					cmd.div_start = 1'b1;
					cmd.div_sel = DSEL_MIN;
					state_d = S_MINW;
				end
			end
			S_MINW: begin
				if (!stat.div_busy) state_d = S_DONE;
			end
			S_WEEKW: begin
				if (!stat.div_busy) state_d = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || !out_stall) begin
					cmd.load_out = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

endmodule

[design/cgtc_datapath.sv]
`timescale 1ns / 1ps
module cgtc_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cgtc_pkg::cgtc_cmd_t  cmd,
	output cgtc_pkg::cgtc_stat_t stat,
	input  logic [1:0]           kind,
	input  logic [11:0]          in_year,
	input  logic [3:0]           in_month,
	input  logic [4:0]           in_day,
	input  logic [4:0]           in_hour,
	input  logic [5:0]           in_minute,
	input  logic [5:0]           in_second,
	input  logic [31:0]          in_seconds,
	output logic                 status,
	output logic [31:0]          out_seconds,
	output logic [11:0]          out_year,
	output logic [3:0]           out_month,
	output logic [4:0]           out_day,
	output logic [4:0]           out_hour,
	output logic [5:0]           out_minute,
	output logic [5:0]           out_second,
	output logic signed [13:0]   gps_week,
	output logic signed [20:0]   time_of_week
);
	import cgtc_pkg::*;

	logic [1:0]  kind_q;
	logic [11:0] year_q;
	logic [3:0]  month_q;
	logic [4:0]  day_q;
	logic [4:0]  hour_in_q;
	logic [5:0]  minute_in_q;
	logic [5:0]  second_in_q;
	logic [31:0] secs_q;

	logic [17:0] days18_q;
	logic [31:0] total_q;
	logic [15:0] days_q;
	logic [16:0] srem_q;
	logic [5:0]  quad_q;
	logic [10:0] d_q;
	logic [5:0]  m_q;
	logic [4:0]  hour_q;
	logic [11:0] mrem_q;
	logic [5:0]  minute_q;
	logic [5:0]  second_q;
	logic        neg_q;
	logic [13:0] week_q;
	logic [20:0] tow_q;

	logic [1:0]  cnt_q;
	logic [2:0]  sel_q;
	logic [31:0] x_q;
	logic [63:0] prod_q;
	logic [31:0] est_q;
	logic [31:0] rem_q;

	// Calendar to seconds.
	logic        cal_ok;
	logic [11:0] yoff;
	logic [11:0] ysince;
	logic [16:0] yterm;
	logic [5:0]  lterm;
	logic        leap_add;
	logic [17:0] days_c;
	logic [31:0] total_c;

	assign cal_ok = (year_q >= YEAR_LO) && (year_q <= YEAR_HI)
		&& (month_q >= 4'd1) && (month_q <= 4'd12);
	assign yoff = year_q - YEAR_LO;
	assign ysince = year_q - 12'd1969;
	assign yterm = 17'(yoff[7:0]) * 17'd365;
	assign lterm = ysince[7:2];
	assign leap_add = (year_q[1:0] == 2'b00) && (month_q >= 4'd3);
	assign days_c = 18'(yterm) + 18'(lterm) + 18'(day_of_year_start(month_q - 4'd1))
		+ 18'(day_q) + 18'(leap_add) - 18'd2;
	assign total_c = 32'({{14{days18_q[17]}}, days18_q}) * 32'd86400
		+ 32'(hour_in_q) * 32'd3600 + 32'(minute_in_q) * 32'd60 + 32'(second_in_q);

	// GPS offset, taken as sign and magnitude so the divider stays unsigned.
	logic [32:0] rel;
	logic [31:0] rel_mag;
	assign rel = {1'b0, secs_q} - GPS_EPOCH;
	assign rel_mag = rel[32] ? 32'(33'd0 - rel) : rel[31:0];

	// Division by a constant: the quotient estimate from a floor(2^32 / divisor)
	// reciprocal is low by at most one, so a back multiply and one compare and
	// subtract finish it.
	logic [19:0] divisor;
	logic [31:0] div32;
	logic [31:0] recip;
	logic [31:0] dividend;
	logic [63:0] prod_c;
	logic [31:0] back;
	logic        rem_ge;
	logic [31:0] q_fin;
	logic [31:0] r_fin;

	always_comb begin
		case (sel_q)
			DSEL_DAY: begin
				divisor = 20'd86400;
				recip = 32'd49710;
			end
			DSEL_QUAD: begin
				divisor = 20'd1461;
				recip = 32'd2939744;
			end
			DSEL_HOUR: begin
				divisor = 20'd3600;
				recip = 32'd1193046;
			end
			DSEL_MIN: begin
				divisor = 20'd60;
				recip = 32'd71582788;
			end
			DSEL_WEEK: begin
				divisor = 20'd604800;
				recip = 32'd7101;
			end
			default: begin
				divisor = 20'd1;
				recip = 32'd0;
			end
		endcase
	end

	always_comb begin
		case (cmd.div_sel)
			DSEL_DAY:  dividend = secs_q;
			DSEL_QUAD: dividend = {16'd0, days_q};
			DSEL_HOUR: dividend = {15'd0, srem_q};
			DSEL_MIN:  dividend = {20'd0, mrem_q};
			DSEL_WEEK: dividend = rel_mag;
			default:   dividend = 32'd0;
		endcase
	end

	assign div32 = {12'd0, divisor};
	assign prod_c = 64'(x_q) * 64'(recip);
	assign back = prod_q[63:32] * div32;
	assign rem_ge = (rem_q >= div32);
	assign q_fin = rem_ge ? est_q + 32'd1 : est_q;
	assign r_fin = rem_ge ? rem_q - div32 : rem_q;

	logic [4:0] mlen;
	logic       walk_go;
	assign mlen = month_len(m_q);
	assign walk_go = (m_q < 6'd48) && (d_q >= 11'(mlen));

	assign stat.kind = kind_q;
	assign stat.div_busy = (cnt_q != 2'd0);
	assign stat.walk_done = !walk_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (cmd.div_start) begin
			cnt_q <= 2'd3;
		end else if (cnt_q != 2'd0) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			kind_q <= kind;
			year_q <= in_year;
			month_q <= in_month;
			day_q <= in_day;
			hour_in_q <= in_hour;
			minute_in_q <= in_minute;
			second_in_q <= in_second;
			secs_q <= in_seconds;
		end
		if (cmd.cal0) days18_q <= days_c;
		if (cmd.cal1) total_q <= total_c;
		if (cmd.div_start) begin
			sel_q <= cmd.div_sel;
			x_q <= dividend;
			if (cmd.div_sel == DSEL_QUAD) m_q <= 6'd0;
			if (cmd.div_sel == DSEL_WEEK) neg_q <= rel[32];
		end else begin
			case (cnt_q)
				2'd3: prod_q <= prod_c;
				2'd2: begin
					est_q <= prod_q[63:32];
					rem_q <= x_q - back;
				end
				2'd1: begin
					case (sel_q)
						DSEL_DAY: begin
							days_q <= q_fin[15:0];
							srem_q <= r_fin[16:0];
						end
						DSEL_QUAD: begin
							quad_q <= q_fin[5:0];
							d_q <= r_fin[10:0];
						end
						DSEL_HOUR: begin
							hour_q <= q_fin[4:0];
							mrem_q <= r_fin[11:0];
						end
						DSEL_MIN: begin
							minute_q <= q_fin[5:0];
							second_q <= r_fin[5:0];
						end
						DSEL_WEEK: begin
							week_q <= neg_q ? 14'(14'd0 - q_fin[13:0]) : q_fin[13:0];
							tow_q <= neg_q ? 21'(21'd0 - r_fin[20:0]) : r_fin[20:0];
						end
						default: ;
					endcase
				end
				default: ;
			endcase
		end
		if (cmd.walk && walk_go) begin
			d_q <= d_q - 11'(mlen);
			m_q <= m_q + 6'd1;
		end
		if (cmd.load_out) begin
			status <= 1'b0;
			out_seconds <= 32'd0;
			out_year <= 12'd0;
			out_month <= 4'd0;
			out_day <= 5'd0;
			out_hour <= 5'd0;
			out_minute <= 6'd0;
			out_second <= 6'd0;
			gps_week <= 14'sd0;
			time_of_week <= 21'sd0;
			case (kind_q)
				KIND_CAL2SEC: begin
					status <= !cal_ok;
					out_seconds <= cal_ok ? total_q : 32'd0;
				end
				KIND_SEC2CAL: begin
					out_year <= YEAR_LO + {4'd0, quad_q, 2'b00} + 12'(div12(m_q));
					out_month <= 4'(m_q - 6'd12 * 6'(div12(m_q))) + 4'd1;
					out_day <= 5'(d_q) + 5'd1;
					out_hour <= hour_q;
					out_minute <= minute_q;
					out_second <= second_q;
				end
				KIND_SEC2GPS: begin
					gps_week <= $signed(week_q);
					time_of_week <= $signed(tow_q);
				end
				default: ;
			endcase
		end
	end

endmodule

[design/calendar_gps_time_converter_unit.sv]
`timescale 1ns / 1ps
// Channel   Handshake                Payload
// input     in_valid / in_stall      kind, in_year .. in_second, in_seconds
// output    out_valid / out_stall    status, out_seconds, out_year .. time_of_week
//
// One item is in work at a time. Seconds to GPS week uses one division by a constant
// (reciprocal multiply, back multiply, correction). Seconds to calendar uses four
// such divisions plus a month walk that steps one month per cycle. Reset clears the
// controller and the output valid; a stalled result is held in the output register
// while the next beat may already be accepted.
module calendar_gps_time_converter_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         kind,
	input  logic [11:0]        in_year,
	input  logic [3:0]         in_month,
	input  logic [4:0]         in_day,
	input  logic [4:0]         in_hour,
	input  logic [5:0]         in_minute,
	input  logic [5:0]         in_second,
	input  logic [31:0]        in_seconds,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               status,
	output logic [31:0]        out_seconds,
	output logic [11:0]        out_year,
	output logic [3:0]         out_month,
	output logic [4:0]         out_day,
	output logic [4:0]         out_hour,
	output logic [5:0]         out_minute,
	output logic [5:0]         out_second,
	output logic signed [13:0] gps_week,
	output logic signed [20:0] time_of_week
);
	import cgtc_pkg::*;

	cgtc_cmd_t  cmd;
	cgtc_stat_t stat;

	cgtc_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.stat(stat),
		.cmd(cmd)
	);

	cgtc_datapath u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.stat(stat),
		.kind(kind),
		.in_year(in_year),
		.in_month(in_month),
		.in_day(in_day),
		.in_hour(in_hour),
		.in_minute(in_minute),
		.in_second(in_second),
		.in_seconds(in_seconds),
		.status(status),
		.out_seconds(out_seconds),
		.out_year(out_year),
		.out_month(out_month),
		.out_day(out_day),
		.out_hour(out_hour),
		.out_minute(out_minute),
		.out_second(out_second),
		.gps_week(gps_week),
		.time_of_week(time_of_week)
	);

endmodule
